FILE: rtl/hsrc_pkg.sv
// hsrc_pkg: shared constants and types of the hold sample rate converter
// no dependencies; used by hsrc_if, hsrc_alu and hold_sample_rate_converter
package hsrc_pkg;

	// sample width of one channel of a pair
	localparam int SAMPLE_BITS = 16;

	// rate registers and configuration port
	localparam int IN_RATE_BITS   = 18;
	localparam int OUT_RATE_BITS  = 17;
	localparam int CFG_DATA_BITS  = 18;
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_RATE  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_RATE = 2'd1;
	localparam logic [IN_RATE_BITS-1:0]  IN_RATE_RESET  = 18'd48000;
	localparam logic [OUT_RATE_BITS-1:0] OUT_RATE_RESET = 17'd48000;

	// phase accumulator, saturating signed
	localparam int ACC_BITS = 20;
	localparam logic signed [ACC_BITS-1:0] ACC_MAX = 20'sh7FFFF;
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = 20'sh80000;

	// repeat limit per input pair
	localparam int COPY_CNT_BITS = 4;
	localparam logic [COPY_CNT_BITS-1:0] LAST_COPY_IDX = 4'd12;

	// operations of the shared adder
	typedef enum logic [1:0] {
		OP_ADD_OUT  = 2'd0,
		OP_SUB_IN   = 2'd1,
		OP_ADD_DIFF = 2'd2
	} alu_op_t;

endpackage

FILE: rtl/hsrc_if.sv
// hsrc_if: valid/ready channels for input pairs and emitted copies
// depends on hsrc_pkg for the default sample width
interface hsrc_pair_if #(
	parameter int SAMPLE_BITS = hsrc_pkg::SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface hsrc_copy_if #(
	parameter int SAMPLE_BITS = hsrc_pkg::SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic                          last_copy;

	modport source (output valid, output out_left, output out_right, output last_copy,
		input ready);
	modport sink (input valid, input out_left, input out_right, input last_copy,
		output ready);
endinterface

FILE: rtl/hsrc_alu.sv
// hsrc_alu: shared saturating adder that moves the phase accumulator
// depends on hsrc_pkg for widths, limits and operation codes
module hsrc_alu (
	input  logic signed [hsrc_pkg::ACC_BITS-1:0]      acc,
	input  logic        [hsrc_pkg::IN_RATE_BITS-1:0]  irate,
	input  logic        [hsrc_pkg::OUT_RATE_BITS-1:0] orate,
	input  hsrc_pkg::alu_op_t                         op,
	output logic signed [hsrc_pkg::ACC_BITS-1:0]      result
);
	localparam int W = hsrc_pkg::ACC_BITS + 2;

	logic signed [W-1:0] irate_s;
	logic signed [W-1:0] orate_s;
	logic signed [W-1:0] addend;
	logic signed [W-1:0] sum;

	// operand selection
	always_comb begin
		irate_s = $signed(W'(irate));
		orate_s = $signed(W'(orate));
		unique case (op)
			hsrc_pkg::OP_ADD_OUT:  addend = orate_s;
			hsrc_pkg::OP_SUB_IN:   addend = -irate_s;
			hsrc_pkg::OP_ADD_DIFF: addend = orate_s - irate_s;
			default:               addend = orate_s;
		endcase
	end

	// add and clamp to the accumulator range
	always_comb begin
		sum = W'(acc) + addend;
		if (sum > W'(hsrc_pkg::ACC_MAX)) begin
			result = hsrc_pkg::ACC_MAX;
		end else if (sum < W'(hsrc_pkg::ACC_MIN)) begin
			result = hsrc_pkg::ACC_MIN;
		end else begin
			result = sum[hsrc_pkg::ACC_BITS-1:0];
		end
	end
endmodule

FILE: rtl/hold_sample_rate_converter.sv
// hold_sample_rate_converter: zero-order-hold rate converter top level
// depends on hsrc_pkg, hsrc_if (channels) and hsrc_alu (shared adder)

// One stereo pair is taken at the input rate and sent on as zero or more copies at the
// output rate, tracked by a 20 bit saturating phase accumulator. A passing pair goes
// through the pass state, a dropped pair the drop state, and a repeated pair the
// repeat-add state and one repeat step per copy for n copies (n at most 13), since
// every accumulator step, including one per copy, goes through a single shared adder.
// Each copy waits for the output register to free up. The user writes rates through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; nothing here enforces it.
module hold_sample_rate_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hsrc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [hsrc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	hsrc_pair_if.sink                            pairs,
	hsrc_copy_if.source                          copies
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PASS = 5'b00010,
		ST_DROP = 5'b00100,
		ST_RADD = 5'b01000,
		ST_REP  = 5'b10000
	} state_t;

	localparam int CW = hsrc_pkg::ACC_BITS + 1;

	state_t                                      state_q;
	logic        [hsrc_pkg::IN_RATE_BITS-1:0]    irate_q;
	logic        [hsrc_pkg::OUT_RATE_BITS-1:0]   orate_q;
	logic signed [hsrc_pkg::ACC_BITS-1:0]        acc_q;
	logic        [hsrc_pkg::COPY_CNT_BITS-1:0]   cnt_q;
	logic signed [hsrc_pkg::SAMPLE_BITS-1:0]     left_q;
	logic signed [hsrc_pkg::SAMPLE_BITS-1:0]     right_q;
	logic                                        out_valid_q;
	logic signed [hsrc_pkg::SAMPLE_BITS-1:0]     out_left_q;
	logic signed [hsrc_pkg::SAMPLE_BITS-1:0]     out_right_q;
	logic                                        out_last_q;

	hsrc_pkg::alu_op_t                           alu_op;
	logic signed [hsrc_pkg::ACC_BITS-1:0]        alu_res;
	logic signed [CW-1:0]                        acc_w;
	logic signed [CW-1:0]                        ir_w;
	logic                                        below_in;
	logic                                        above_neg_in;
	logic                                        below_twice_in;
	logic                                        in_fire;
	logic                                        out_free;
	logic                                        load_out;
	logic                                        rep_last;
	logic                                        acc_en;

	// handshake and compares against the rates
	always_comb begin
		in_fire        = pairs.valid && pairs.ready;
		out_free       = !out_valid_q || copies.ready;
		acc_w          = CW'(acc_q);
		ir_w           = $signed(CW'(irate_q));
		below_in       = acc_w < ir_w;
		above_neg_in   = acc_w > -ir_w;
		below_twice_in = acc_w < $signed({2'b00, irate_q, 1'b0});
		rep_last       = below_twice_in || (cnt_q == hsrc_pkg::LAST_COPY_IDX);
		load_out       = out_free && ((state_q == ST_PASS) || (state_q == ST_REP));
	end

	assign pairs.ready = (state_q == ST_IDLE);

	// shared adder operation per state
	always_comb begin
		unique case (state_q)
			ST_PASS: alu_op = hsrc_pkg::OP_ADD_DIFF;
			ST_REP:  alu_op = hsrc_pkg::OP_SUB_IN;
			default: alu_op = hsrc_pkg::OP_ADD_OUT;
		endcase
		acc_en = load_out || (state_q == ST_DROP) || (state_q == ST_RADD);
	end

	hsrc_alu u_alu (
		.acc    (acc_q),
		.irate  (irate_q),
		.orate  (orate_q),
		.op     (alu_op),
		.result (alu_res)
	);

	// rate registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irate_q <= hsrc_pkg::IN_RATE_RESET;
			orate_q <= hsrc_pkg::OUT_RATE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == hsrc_pkg::REG_INPUT_RATE) begin
				irate_q <= cfg_wdata[hsrc_pkg::IN_RATE_BITS-1:0];
			end else if (cfg_index == hsrc_pkg::REG_OUTPUT_RATE) begin
				orate_q <= cfg_wdata[hsrc_pkg::OUT_RATE_BITS-1:0];
			end
		end
	end

	// sequencer, accumulator and copy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (acc_en) begin
				acc_q <= alu_res;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) begin
						priority if (below_in && above_neg_in) begin
							state_q <= ST_PASS;
						end else if (!below_in) begin
							state_q <= ST_RADD;
						end else begin
							state_q <= ST_DROP;
						end
					end
				end
				ST_PASS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DROP: state_q <= ST_IDLE;
				ST_RADD: state_q <= ST_REP;
				ST_REP: begin
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (rep_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held input pair
	always_ff @(posedge clk) begin
		if (in_fire) begin
			left_q  <= pairs.left_sample;
			right_q <= pairs.right_sample;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (copies.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_left_q  <= left_q;
			out_right_q <= right_q;
			out_last_q  <= (state_q == ST_PASS) || rep_last;
		end
	end

	assign copies.valid     = out_valid_q;
	assign copies.out_left  = out_left_q;
	assign copies.out_right = out_right_q;
	assign copies.last_copy = out_last_q;

	// an accepted pair always moves the sequencer out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after a pair was accepted");

	// every repeat step starts with the accumulator at or above the input rate
	a_repeat_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REP) |-> !below_in)
		else $error("repeat step with accumulator below input rate");

	// copy count never passes the repeat limit
	a_copy_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REP) |-> (cnt_q <= hsrc_pkg::LAST_COPY_IDX))
		else $error("copy count beyond limit");

	// the final copy of a pair returns the sequencer to idle
	a_last_ends_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (state_q == ST_REP) && rep_last) |=> (state_q == ST_IDLE))
		else $error("sequencer kept repeating after the final copy");
endmodule
